### src/sal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sal_pkg: shared types and constants for the sorted linked list
// Item structs, command and status codes and the controller state type.
// ----------------------------------------------------------------------------
package sal_pkg;

  localparam int DEFAULT_CAPACITY = 8;
  localparam int KEY_W            = 32;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_DISPLAY = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                    command;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic                    entry_valid;
    logic signed [KEY_W-1:0] out_key;
    logic                    last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_POP,
    S_WALK,
    S_LINK,
    S_LINK2,
    S_SHOW,
    S_EMIT
  } sal_state_t;

endpackage

### src/sal_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sal_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module sal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/sal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sal_ctrl: list walker and memory owner
// Holds the slot memories (key plus next link, and free chain links) and
// the sequencer that walks, relinks and emits results.
// ----------------------------------------------------------------------------
module sal_ctrl #(
  parameter int CAPACITY = sal_pkg::DEFAULT_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sal_pkg::in_item_t  in_data,
  output logic               emit_valid,
  input  logic               emit_ready,
  output sal_pkg::out_item_t emit_data
);
  import sal_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int ENT_W  = KEY_W + IDX_W;
  localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(CAPACITY);

  sal_state_t state, state_next;

  cmd_t                    cmd, cmd_next;
  logic signed [KEY_W-1:0] key, key_next;
  logic signed [KEY_W-1:0] prev_key, prev_key_next;
  logic [IDX_W-1:0]        slot, slot_next;
  logic [IDX_W-1:0]        cur, cur_next;
  logic [IDX_W-1:0]        prev, prev_next;
  logic [IDX_W-1:0]        list_head, list_head_next;
  logic [IDX_W-1:0]        free_head, free_head_next;
  logic [IDX_W-1:0]        fill, fill_next;
  status_t                 status, status_next;

  // Entry memory: {key, next link}; free memory: next link of the free chain.
  logic              e_we, e_re, f_we, f_re;
  logic [ADDR_W-1:0] e_waddr, e_raddr, f_waddr, f_raddr;
  logic [ENT_W-1:0]  e_wdata, e_rdata;
  logic [IDX_W-1:0]  f_wdata, f_rdata;

  sal_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  sal_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (f_re),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  logic signed [KEY_W-1:0] e_key;
  logic [IDX_W-1:0]        e_link, e_link_n;
  logic                    next_null, key_gt, key_eq;
  logic                    head_null, free_null, cur_null, prev_null, slot_fresh;

  assign e_key      = e_rdata[IDX_W +: KEY_W];
  assign e_link     = e_rdata[IDX_W-1:0];
  // Any link outside the pool counts as the end of the chain.
  assign next_null  = (e_link >= NULL_IDX);
  assign e_link_n   = next_null ? NULL_IDX : e_link;
  assign key_gt     = (key > e_key);
  assign key_eq     = (key == e_key);
  assign head_null  = (list_head >= NULL_IDX);
  assign free_null  = (free_head >= NULL_IDX);
  assign cur_null   = (cur >= NULL_IDX);
  assign prev_null  = (prev >= NULL_IDX);
  // Slots at or above the fill mark were never handed out; their free link
  // is implied as the next slot up, so the free memory needs no reset.
  assign slot_fresh = (slot >= fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      list_head <= NULL_IDX;
      free_head <= '0;
      fill      <= '0;
    end else begin
      state     <= state_next;
      list_head <= list_head_next;
      free_head <= free_head_next;
      fill      <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    key      <= key_next;
    prev_key <= prev_key_next;
    slot     <= slot_next;
    cur      <= cur_next;
    prev     <= prev_next;
    status   <= status_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        unique case (cmd)
          CMD_CLEAR:   state_next = S_EMIT;
          CMD_INSERT:  state_next = free_null ? S_EMIT : S_POP;
          CMD_DELETE:  state_next = head_null ? S_EMIT : S_WALK;
          CMD_DISPLAY: state_next = head_null ? S_EMIT : S_SHOW;
          default:     state_next = S_EMIT;
        endcase
      end
      S_POP: begin
        state_next = cur_null ? S_LINK : S_WALK;
      end
      S_WALK: begin
        if (cmd == CMD_INSERT) begin
          state_next = (key_gt && !next_null) ? S_WALK : S_LINK;
        end else begin
          state_next = (key_eq || next_null) ? S_EMIT : S_WALK;
        end
      end
      S_LINK: begin
        state_next = prev_null ? S_EMIT : S_LINK2;
      end
      S_LINK2: begin
        state_next = S_EMIT;
      end
      S_SHOW: begin
        if (emit_ready && next_null) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (emit_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_next       = cmd;
    key_next       = key;
    prev_key_next  = prev_key;
    slot_next      = slot;
    cur_next       = cur;
    prev_next      = prev;
    list_head_next = list_head;
    free_head_next = free_head;
    fill_next      = fill;
    status_next    = status;
    in_ready       = 1'b0;
    e_we           = 1'b0;
    e_waddr        = slot[ADDR_W-1:0];
    e_wdata        = {key, cur};
    e_re           = 1'b0;
    e_raddr        = e_link_n[ADDR_W-1:0];
    f_we           = 1'b0;
    f_waddr        = cur[ADDR_W-1:0];
    f_wdata        = free_head;
    f_re           = 1'b0;
    f_raddr        = free_head[ADDR_W-1:0];
    emit_valid     = 1'b0;
    emit_data      = '{status: status, entry_valid: 1'b0, out_key: '0, last: 1'b1};

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_next = in_data.command;
          key_next = in_data.key;
        end
      end
      S_START: begin
        cur_next    = list_head;
        prev_next   = NULL_IDX;
        status_next = ST_DONE;
        unique case (cmd)
          CMD_CLEAR: begin
            list_head_next = NULL_IDX;
            free_head_next = '0;
            fill_next      = '0;
          end
          CMD_INSERT: begin
            slot_next = free_head;
            if (free_null) begin
              status_next = ST_FULL;
            end else begin
              f_re = 1'b1;
            end
          end
          CMD_DELETE: begin
            e_raddr = list_head[ADDR_W-1:0];
            if (head_null) begin
              status_next = ST_NOT_FOUND;
            end else begin
              e_re = 1'b1;
            end
          end
          CMD_DISPLAY: begin
            e_raddr = list_head[ADDR_W-1:0];
            if (head_null) begin
              status_next = ST_EMPTY;
            end else begin
              e_re = 1'b1;
            end
          end
          default: status_next = ST_DONE;
        endcase
      end
      S_POP: begin
        if (slot_fresh) begin
          free_head_next = fill + IDX_W'(1);
          fill_next      = fill + IDX_W'(1);
        end else begin
          free_head_next = f_rdata;
        end
        e_raddr = cur[ADDR_W-1:0];
        e_re    = !cur_null;
      end
      S_WALK: begin
        if (cmd == CMD_INSERT) begin
          if (key_gt) begin
            prev_next     = cur;
            prev_key_next = e_key;
            cur_next      = e_link_n;
            e_re          = !next_null;
          end
        end else if (key_eq) begin
          // Unlink the match and push its slot onto the free chain.
          status_next = ST_DONE;
          if (prev_null) begin
            list_head_next = e_link_n;
          end else begin
            e_we    = 1'b1;
            e_waddr = prev[ADDR_W-1:0];
            e_wdata = {prev_key, e_link_n};
          end
          f_we           = 1'b1;
          free_head_next = cur;
        end else begin
          prev_next     = cur;
          prev_key_next = e_key;
          cur_next      = e_link_n;
          if (next_null) begin
            status_next = ST_NOT_FOUND;
          end else begin
            e_re = 1'b1;
          end
        end
      end
      S_LINK: begin
        e_we        = 1'b1;
        status_next = ST_DONE;
        if (prev_null) begin
          list_head_next = slot;
        end
      end
      S_LINK2: begin
        e_we    = 1'b1;
        e_waddr = prev[ADDR_W-1:0];
        e_wdata = {prev_key, slot};
      end
      S_SHOW: begin
        emit_valid = 1'b1;
        emit_data  = '{status: ST_DONE, entry_valid: 1'b1, out_key: e_key, last: next_null};
        e_re       = emit_ready && !next_null;
      end
      S_EMIT: begin
        emit_valid = 1'b1;
      end
      default: in_ready = 1'b0;
    endcase
  end

endmodule

### src/sorted_array_list_with_free_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_array_list_with_free_list: sorted key list in a fixed slot pool
// Insert, delete, in-order display and clear over linked slots kept in
// memory, with a free chain for unused slots and a registered result port.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  input    | in_valid / in_ready  | in_data  (command, key)
//  output   | out_valid / out_ready| out_data (status, entry_valid, out_key, last)
//
// One item is worked on at a time. Insert pops a free slot, walks the list
// and writes the entry (and relinks the one before it, if any); delete
// walks and unlinks a match. The walk reads the entry memory once per
// slot, at most CAPACITY slots. Clear, a full pool and the empty cases skip
// the walk; display gives one result per cycle while the output is ready.
// Reset is synchronous and leaves the list empty at once, with no memory
// sweep. A stalled output holds the walk in place without losing a result.
// ----------------------------------------------------------------------------
module sorted_array_list_with_free_list #(
  parameter int CAPACITY = sal_pkg::DEFAULT_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sal_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sal_pkg::out_item_t out_data
);
  import sal_pkg::*;

  logic      emit_valid, emit_ready;
  out_item_t emit_data;

  sal_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_data  (emit_data)
  );

  // The output register frees the controller as soon as a result is taken.
  assign emit_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      out_data <= emit_data;
    end
  end

  // A result without a listed key is always the single, final result.
  a_plain_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.entry_valid |-> out_data.last && out_data.out_key == '0)
    else $error("result without a key is not a final zero result");

  // Listed keys only come out of a successful display.
  a_entry_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.entry_valid |-> out_data.status == ST_DONE)
    else $error("listed key carries a failure status");

  // An accepted item keeps the input closed for at least the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input reopened right after an item was taken");

endmodule
